@@ rtl/id3u8_pkg.sv @@
// shared constants and types for the id3 text to utf-8 transcoder
package id3u8_pkg;

    localparam int MAX_TEXT   = 128;
    localparam int LIMIT_W    = 7;
    localparam int GROUP_SIZE = 4;
    localparam int GROUP_CW   = $clog2(GROUP_SIZE + 1);

    // clamp of the limit register, never above what the register can hold
    localparam logic [LIMIT_W-1:0] LIMIT_MAX =
        (MAX_TEXT - 1 >= (1 << LIMIT_W) - 1) ? '1 : LIMIT_W'(MAX_TEXT - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(127);

    typedef enum logic [1:0] {
        ENC_LATIN1  = 2'd0,
        ENC_UTF16   = 2'd1,
        ENC_UTF16BE = 2'd2,
        ENC_UTF8    = 2'd3
    } enc_t;

    localparam logic [7:0] BOM_FF    = 8'hFF;
    localparam logic [7:0] BOM_FE    = 8'hFE;
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] CONT      = 8'h80;
    localparam logic [15:0] CP_2BYTE = 16'h0080;
    localparam logic [15:0] CP_3BYTE = 16'h0800;

endpackage

@@ rtl/id3_text_to_utf8.sv @@
// id3 text-frame body to utf-8 transcoder, top level
//
// s_ channel takes one body byte per request: s_tdata is the byte, s_tlast marks
// the final byte of the body, s_tuser[0] marks the first byte and s_tuser[2:1]
// carries the encoding code (0 latin-1, 1 utf-16 with mark, 2 utf-16be, 3 utf-8),
// sampled only with the first byte.
// m_tdata carries utf-8 bytes, m_tlast flags the terminating zero byte.
// cfg_we / cfg_wdata set the output byte limit (reset 127); write only when idle.
// Each accepted byte is decoded in the cycle it is taken into a group register of
// up to four output bytes (three for a code point plus the terminator). The first
// output byte is on m_ the cycle after acceptance; the group drains one byte per
// cycle while m_tready is high, and the next request is taken in the cycle the
// last byte of the group leaves, so a new byte waits until its group is out.
// The one-byte-wide output port thus sets the pace for multi-byte groups.
// Bytes that produce nothing pass at one per cycle.
// Reset empties the group (its count, not its bytes) and leaves the block idle until a first byte.
// A stall on m_ holds the current byte and stops s_tready once the group is
// down to its last byte.
module id3_text_to_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // in_byte
    input  logic       s_tlast,     // last_byte
    input  logic [2:0] s_tuser,     // first_byte, text_encoding[1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte
    output logic       m_tlast,     // end_of_string
    input  logic       cfg_we,
    input  logic [id3u8_pkg::LIMIT_W-1:0] cfg_wdata
);
    import id3u8_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;

    enc_t               enc_reg,      enc_next;
    logic               be_reg,       be_next;
    logic               phase_reg,    phase_next;
    logic [7:0]         held_reg,     held_next;
    logic               fpair_reg,    fpair_next;
    logic [LIMIT_W-1:0] cnt_reg,      cnt_next;
    logic               stop_reg,     stop_next;

    logic [7:0]          grp_reg [GROUP_SIZE];
    logic [7:0]          grp_next [GROUP_SIZE];
    logic [GROUP_CW-1:0] gcnt_reg,  gcnt_next;
    logic                geos_reg,  geos_next;

    logic s_acc, m_acc;
    assign s_tready = (gcnt_reg == '0) || (gcnt_reg == GROUP_CW'(1) && m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (gcnt_reg != '0);
    assign m_acc    = m_tvalid && m_tready;
    assign m_tdata  = grp_reg[0];
    assign m_tlast  = geos_reg && (gcnt_reg == GROUP_CW'(1));

    // decode of one body byte
    always_comb begin
        logic               first;
        logic [7:0]         b;
        logic [LIMIT_W-1:0] lim;
        logic               emit;
        logic               term;
        logic [1:0]         need;
        logic [15:0]        cp;
        logic               skip;
        logic               cp_path;

        first = s_tuser[0];
        b     = s_tdata;
        lim   = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;

        enc_next   = first ? enc_t'(s_tuser[2:1]) : enc_reg;
        be_next    = first ? (s_tuser[2:1] == ENC_UTF16BE) : be_reg;
        phase_next = first ? 1'b0 : phase_reg;
        held_next  = first ? 8'h00 : held_reg;
        fpair_next = first ? 1'b1 : fpair_reg;
        cnt_next   = first ? '0 : cnt_reg;
        stop_next  = first ? 1'b0 : stop_reg;

        emit    = 1'b0;
        term    = 1'b0;
        skip    = 1'b0;
        cp_path = 1'b0;
        cp      = {8'h00, b};
        need    = 2'd1;

        if (!stop_next) begin
            case (enc_next)
                ENC_UTF16, ENC_UTF16BE: begin
                    if (!phase_next) begin
                        held_next  = b;
                        phase_next = 1'b1;
                    end else begin
                        phase_next = 1'b0;
                        if (fpair_next && enc_next == ENC_UTF16) begin
                            if (held_next == BOM_FF && b == BOM_FE) begin
                                be_next = 1'b0;
                                skip    = 1'b1;
                            end else if (held_next == BOM_FE && b == BOM_FF) begin
                                be_next = 1'b1;
                                skip    = 1'b1;
                            end
                        end
                        fpair_next = 1'b0;
                        cp = be_next ? {held_next, b} : {b, held_next};
                        if (!skip) begin
                            if (cp == 16'h0000) term = 1'b1;
                            else cp_path = 1'b1;
                        end
                    end
                end
                ENC_UTF8: begin
                    if (b == 8'h00 || cnt_next >= lim) begin
                        term = 1'b1;
                    end else begin
                        emit     = 1'b1;
                        need     = 2'd1;
                        cnt_next = cnt_next + LIMIT_W'(1);
                    end
                end
                default: begin
                    if (b == 8'h00) term = 1'b1;
                    else cp_path = 1'b1;
                end
            endcase

            if (cp_path) begin
                need = (cp < CP_2BYTE) ? 2'd1 : ((cp < CP_3BYTE) ? 2'd2 : 2'd3);
                // a character that does not fit the remaining room is dropped
                if (({1'b0, cnt_next} + {6'b0, need}) <= {1'b0, lim}) begin
                    emit     = 1'b1;
                    cnt_next = cnt_next + LIMIT_W'(need);
                end
            end
            if (s_tlast) term = 1'b1;
            if (term) stop_next = 1'b1;
        end

        for (int i = 0; i < GROUP_SIZE; i++) grp_next[i] = 8'h00;
        if (emit) begin
            case (need)
                2'd2: begin
                    grp_next[0] = LEAD2 | {3'b000, cp[10:6]};
                    grp_next[1] = CONT | {2'b00, cp[5:0]};
                end
                2'd3: begin
                    grp_next[0] = LEAD3 | {4'b0000, cp[15:12]};
                    grp_next[1] = CONT | {2'b00, cp[11:6]};
                    grp_next[2] = CONT | {2'b00, cp[5:0]};
                end
                default: grp_next[0] = cp[7:0];
            endcase
        end
        // the zero bytes left after the character serve as the terminator
        gcnt_next = (emit ? GROUP_CW'(need) : '0) + GROUP_CW'(term);
        geos_next = term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RST;
            enc_reg   <= ENC_LATIN1;
            be_reg    <= 1'b0;
            phase_reg <= 1'b0;
            held_reg  <= 8'h00;
            fpair_reg <= 1'b1;
            cnt_reg   <= '0;
            stop_reg  <= 1'b1;
            gcnt_reg  <= '0;
            geos_reg  <= 1'b0;
        end else begin
            if (cfg_we) limit_reg <= cfg_wdata;
            if (s_acc) begin
                enc_reg   <= enc_next;
                be_reg    <= be_next;
                phase_reg <= phase_next;
                held_reg  <= held_next;
                fpair_reg <= fpair_next;
                cnt_reg   <= cnt_next;
                stop_reg  <= stop_next;
                gcnt_reg  <= gcnt_next;
                geos_reg  <= geos_next;
            end else if (m_acc) begin
                gcnt_reg <= gcnt_reg - GROUP_CW'(1);
            end
        end
    end

    // group bytes are payload, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < GROUP_SIZE; i++) grp_reg[i] <= grp_next[i];
        end else if (m_acc) begin
            for (int i = 0; i < GROUP_SIZE - 1; i++) grp_reg[i] <= grp_reg[i + 1];
            grp_reg[GROUP_SIZE - 1] <= 8'h00;
        end
    end

endmodule

@@ rtl/id3u8_chk.sv @@
// port-level checker for the id3 text to utf-8 transcoder and its bind
module id3u8_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled output byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output byte changed while stalled");

    // the terminator is a zero byte
    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 8'h00)
        else $error("terminator is not zero");

    // text bytes are never zero
    a_text_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata != 8'h00)
        else $error("zero byte inside the string");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind id3_text_to_utf8 id3u8_chk u_chk (.*);
